>>> design/svt_pkg.sv
package svt_pkg;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_ADD    = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         operation;
        logic [4:0]         scope;
        logic               scope_present;
        logic signed [31:0] var_key;
    } t_in_item;

    typedef struct packed {
        logic       status;
        logic [4:0] result_scope;
        logic       result_scope_valid;
        logic [5:0] slot;
        logic [5:0] free_scopes;
        logic [6:0] free_slots;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PUSH,
        ST_POP_RD,
        ST_POP_STEP,
        ST_POP_END,
        ST_FIND_RD,
        ST_FIND_STEP,
        ST_FIND_NEXT,
        ST_ALLOC,
        ST_ALLOC_LINK,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_scope;
        logic rd_slot;
        logic do_push;
        logic pop_step;
        logic pop_end;
        logic find_start;
        logic find_next;
        logic alloc;
        logic alloc_link;
        logic set_fail;
        logic set_found;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic present;
        logic scope_empty;
        logic slot_empty;
        logic list_end;
        logic hit;
        logic chain_end;
    } t_status;

endpackage

>>> design/svt_ram.sv
module svt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/svt_ctrl.sv
module svt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  svt_pkg::t_status i_stat,
    output svt_pkg::t_cmd   o_cmd
);
    import svt_pkg::*;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_DECODE;
            ST_DECODE: begin
                unique case (i_stat.op)
                    OP_PUSH: n_state = i_stat.scope_empty ? ST_DONE : ST_PUSH;
                    OP_POP:  n_state = i_stat.present ? ST_POP_RD : ST_DONE;
                    default: n_state = i_stat.present ? ST_FIND_RD : ST_DONE;
                endcase
            end
            ST_PUSH:     n_state = ST_DONE;
            ST_POP_RD:   n_state = ST_POP_STEP;
            ST_POP_STEP: n_state = i_stat.list_end ? ST_POP_END : ST_POP_STEP;
            ST_POP_END:  n_state = ST_DONE;
            ST_FIND_RD:  n_state = ST_FIND_STEP;
            ST_FIND_STEP: begin
                if (i_stat.hit) begin
                    n_state = ST_DONE;
                end else if (i_stat.list_end) begin
                    if (i_stat.op == OP_ADD) begin
                        n_state = i_stat.slot_empty ? ST_DONE : ST_ALLOC;
                    end else begin
                        n_state = i_stat.chain_end ? ST_DONE : ST_FIND_NEXT;
                    end
                end
            end
            ST_FIND_NEXT:  n_state = ST_FIND_RD;
            ST_ALLOC:      n_state = ST_ALLOC_LINK;
            ST_ALLOC_LINK: n_state = ST_DONE;
            ST_DONE:       if (i_out_ready) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_DECODE: begin
                o_cmd.rd_scope = 1'b1;
                if (i_stat.op == OP_PUSH) begin
                    o_cmd.set_fail = i_stat.scope_empty;
                end else begin
                    o_cmd.set_fail = !i_stat.present;
                end
            end
            ST_PUSH:     o_cmd.do_push = 1'b1;
            ST_POP_RD:   o_cmd.rd_slot = 1'b1;
            ST_POP_STEP: o_cmd.pop_step = 1'b1;
            ST_POP_END:  o_cmd.pop_end = 1'b1;
            ST_FIND_RD:  o_cmd.find_start = 1'b1;
            ST_FIND_STEP: begin
                o_cmd.find_next = 1'b1;
                o_cmd.set_found = i_stat.hit;
                if (!i_stat.hit && i_stat.list_end) begin
                    if (i_stat.op == OP_ADD) begin
                        o_cmd.set_fail = i_stat.slot_empty;
                    end else begin
                        o_cmd.set_fail = i_stat.chain_end;
                    end
                end
            end
            ST_FIND_NEXT:  o_cmd.rd_scope = 1'b1;
            ST_ALLOC:      o_cmd.alloc = 1'b1;
            ST_ALLOC_LINK: o_cmd.alloc_link = 1'b1;
            ST_DONE:       o_out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

>>> design/svt_datapath.sv
module svt_datapath #(
    parameter int SCOPE_COUNT = 32,
    parameter int SLOT_COUNT  = 64,
    parameter int KEY_WIDTH   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  svt_pkg::t_in_item i_item,
    input  svt_pkg::t_cmd     i_cmd,
    output svt_pkg::t_status  o_stat,
    output svt_pkg::t_out_item o_item
);
    import svt_pkg::*;

    localparam int SCW = $clog2(SCOPE_COUNT);
    localparam int SLW = $clog2(SLOT_COUNT);
    // links carry one extra bit for "none"
    localparam int SCL = $clog2(SCOPE_COUNT + 1);
    localparam int SLL = $clog2(SLOT_COUNT + 1);
    localparam logic [SCL-1:0] NO_SCOPE = SCL'(SCOPE_COUNT);
    localparam logic [SLL-1:0] NO_SLOT  = SLL'(SLOT_COUNT);
    localparam logic [SCL-1:0] SC_FULL  = SCL'(SCOPE_COUNT);
    localparam logic [SLL-1:0] SL_FULL  = SLL'(SLOT_COUNT);

    // captured request
    t_op                r_op;
    logic               r_present;
    logic [SCW-1:0]     r_req_scope;
    logic [KEY_WIDTH-1:0] r_key;
    logic [SCW-1:0]     r_cur;        // scope being searched
    logic [$clog2(SCOPE_COUNT+1)-1:0] r_hops;

    // per-scope tables in flip-flops (fixed-size, valid after reset)
    logic [SCL-1:0] r_outer [SCOPE_COUNT];
    logic [SLL-1:0] r_first [SCOPE_COUNT];
    logic [SLL-1:0] r_last  [SCOPE_COUNT];

    // free queues: a cell not yet written reads as its own index
    logic [SCOPE_COUNT-1:0] r_sq_wr;
    logic [SLOT_COUNT-1:0]  r_vq_wr;
    logic [SCW-1:0] r_sq [SCOPE_COUNT];
    logic [SCW-1:0] r_sq_head, r_sq_tail;
    logic [SLW-1:0] r_vq_head, r_vq_tail;
    logic [SCL-1:0] r_sq_cnt;
    logic [SLL-1:0] r_vq_cnt;

    // walk state
    logic [SLL-1:0] r_v;
    logic [SLL-1:0] r_steps;
    logic [SLW-1:0] r_new;

    // result
    logic           r_status;
    logic [4:0]     r_rscope;
    logic           r_rvalid;
    logic [5:0]     r_rslot;

    // slot rams: key, next link, owner and free queue
    logic           key_we, nxt_we, own_we, vq_we;
    logic [SLW-1:0] key_wa, nxt_wa, own_wa, ram_ra;
    logic [KEY_WIDTH-1:0] key_rd;
    logic [SLL-1:0] nxt_wd, nxt_rd;
    logic [SCL-1:0] own_wd, own_rd;
    logic [SLW-1:0] vq_rd;

    svt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(SLOT_COUNT)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_wa), .i_wdata(r_key),
        .i_raddr(ram_ra), .o_rdata(key_rd)
    );
    svt_ram #(.WIDTH(SLL), .DEPTH(SLOT_COUNT)) u_next (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(ram_ra), .o_rdata(nxt_rd)
    );
    // owner is never cleared at reset: a slot is only reached through a
    // link after its allocation wrote the owner
    svt_ram #(.WIDTH(SCL), .DEPTH(SLOT_COUNT)) u_owner (
        .i_clk(i_clk), .i_we(own_we), .i_waddr(own_wa), .i_wdata(own_wd),
        .i_raddr(ram_ra), .o_rdata(own_rd)
    );

    logic [SLL-1:0] first_cur, first_req, last_req;
    logic           v_end, hit;
    logic [SLW-1:0] v_idx, head_slot;
    logic [SCW-1:0] head_scope;
    logic [SCL-1:0] outer_cur;

    // free slot queue, read continuously at the head
    svt_ram #(.WIDTH(SLW), .DEPTH(SLOT_COUNT)) u_vq (
        .i_clk(i_clk), .i_we(vq_we), .i_waddr(r_vq_tail), .i_wdata(v_idx),
        .i_raddr(r_vq_head), .o_rdata(vq_rd)
    );

    assign first_cur  = r_first[r_cur];
    assign first_req  = r_first[r_req_scope];
    assign last_req   = r_last[r_req_scope];
    assign outer_cur  = r_outer[r_cur];
    assign v_idx      = r_v[SLW-1:0];
    assign v_end      = (r_v >= NO_SLOT) || (r_steps >= NO_SLOT);
    assign hit        = !v_end && (own_rd == SCL'(r_cur))
                        && (key_rd == r_key);
    assign head_slot  = r_vq_wr[r_vq_head] ? vq_rd : r_vq_head;
    assign head_scope = r_sq_wr[r_sq_head] ? r_sq[r_sq_head] : r_sq_head;
    assign vq_we      = i_cmd.pop_step && !v_end && (r_vq_cnt < SL_FULL);

    // ram read address follows the walk pointer (or the next hop, or a scope's first slot at a walk's start)
    always_comb begin
        ram_ra = v_idx;
        if (i_cmd.find_next || i_cmd.pop_step) begin
            ram_ra = nxt_rd[SLW-1:0];
        end else if (i_cmd.find_start) begin
            ram_ra = first_cur[SLW-1:0];
        end else if (i_cmd.rd_slot) begin
            ram_ra = first_req[SLW-1:0];
        end
    end

    // ram writes
    always_comb begin
        key_we = i_cmd.alloc;
        key_wa = head_slot;
        nxt_we = 1'b0;
        nxt_wa = r_new;
        nxt_wd = NO_SLOT;
        own_we = 1'b0;
        own_wa = v_idx;
        own_wd = NO_SCOPE;
        if (i_cmd.alloc) begin
            nxt_we = 1'b1;
            nxt_wa = head_slot;
            own_we = 1'b1;
            own_wa = head_slot;
            own_wd = SCL'(r_req_scope);
        end else if (i_cmd.alloc_link) begin
            nxt_we = last_req < NO_SLOT;
            nxt_wa = last_req[SLW-1:0];
            nxt_wd = SLL'(r_new);
        end else if (i_cmd.pop_step && !v_end) begin
            nxt_we = 1'b1;
            nxt_wa = v_idx;
            own_we = 1'b1;
        end
    end

    assign o_stat.op          = r_op;
    assign o_stat.present     = r_present;
    assign o_stat.scope_empty = (r_sq_cnt == '0);
    assign o_stat.slot_empty  = (r_vq_cnt == '0);
    assign o_stat.list_end    = v_end;
    assign o_stat.hit         = hit;
    assign o_stat.chain_end   = (outer_cur >= NO_SCOPE)
                                || (r_hops + 1'b1 >= SCL'(SCOPE_COUNT));

    // control-carrying state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SCOPE_COUNT; i++) begin
                r_outer[i] <= NO_SCOPE;
                r_first[i] <= NO_SLOT;
                r_last[i]  <= NO_SLOT;
            end
            r_sq_wr   <= '0;
            r_vq_wr   <= '0;
            r_sq_head <= '0;
            r_sq_tail <= '0;
            r_vq_head <= '0;
            r_vq_tail <= '0;
            r_sq_cnt  <= SC_FULL;
            r_vq_cnt  <= SL_FULL;
        end else begin
            if (i_cmd.do_push) begin
                r_outer[head_scope] <= r_present ? SCL'(r_req_scope) : NO_SCOPE;
                r_first[head_scope] <= NO_SLOT;
                r_last[head_scope]  <= NO_SLOT;
                r_sq_head <= (r_sq_head == SCW'(SCOPE_COUNT - 1)) ? '0
                             : r_sq_head + 1'b1;
                r_sq_cnt  <= r_sq_cnt - 1'b1;
            end
            if (vq_we) begin
                r_vq_wr[r_vq_tail] <= 1'b1;
                r_vq_tail <= (r_vq_tail == SLW'(SLOT_COUNT - 1)) ? '0
                             : r_vq_tail + 1'b1;
                r_vq_cnt  <= r_vq_cnt + 1'b1;
            end
            if (i_cmd.pop_end) begin
                r_first[r_req_scope] <= NO_SLOT;
                r_last[r_req_scope]  <= NO_SLOT;
                r_outer[r_req_scope] <= NO_SCOPE;
                if (r_sq_cnt < SC_FULL) begin
                    r_sq[r_sq_tail]    <= r_req_scope;
                    r_sq_wr[r_sq_tail] <= 1'b1;
                    r_sq_tail <= (r_sq_tail == SCW'(SCOPE_COUNT - 1)) ? '0
                                 : r_sq_tail + 1'b1;
                    r_sq_cnt  <= r_sq_cnt + 1'b1;
                end
            end
            if (i_cmd.alloc) begin
                r_vq_head <= (r_vq_head == SLW'(SLOT_COUNT - 1)) ? '0
                             : r_vq_head + 1'b1;
                r_vq_cnt  <= r_vq_cnt - 1'b1;
            end
            if (i_cmd.alloc_link) begin
                if (last_req >= NO_SLOT) begin
                    r_first[r_req_scope] <= SLL'(r_new);
                end
                r_last[r_req_scope] <= SLL'(r_new);
            end
        end
    end

    // request, walk and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= t_op'(i_item.operation);
            r_req_scope <= SCW'(i_item.scope);
            r_cur       <= SCW'(i_item.scope);
            r_present   <= i_item.scope_present
                           && (32'(i_item.scope) < SCOPE_COUNT);
            r_key       <= KEY_WIDTH'(i_item.var_key);
            r_hops      <= '0;
            r_status    <= 1'b0;
            r_rscope    <= '0;
            r_rvalid    <= 1'b0;
            r_rslot     <= '0;
        end
        if (i_cmd.set_fail) begin
            r_status <= 1'b1;
        end
        if (i_cmd.do_push) begin
            r_rscope <= 5'(head_scope);
            r_rvalid <= 1'b1;
        end
        if (i_cmd.rd_slot) begin
            r_v     <= first_req;
            r_steps <= '0;
        end
        if (i_cmd.find_start) begin
            r_v     <= first_cur;
            r_steps <= '0;
        end
        if (i_cmd.pop_step || i_cmd.find_next) begin
            r_v     <= nxt_rd;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.pop_end) begin
            r_rscope <= 5'(r_outer[r_req_scope]);
            r_rvalid <= r_outer[r_req_scope] < NO_SCOPE;
        end
        if (i_cmd.set_found) begin
            r_rslot <= 6'(v_idx);
        end
        if (i_cmd.rd_scope && r_op == OP_LOOKUP && r_hops != '0) begin
            r_cur <= outer_cur[SCW-1:0];
        end
        if (i_cmd.find_next && !hit && v_end) begin
            r_hops <= r_hops + 1'b1;
        end
        if (i_cmd.alloc) begin
            r_new   <= head_slot;
            r_rslot <= 6'(head_slot);
        end
    end

    assign o_item.status             = r_status;
    assign o_item.result_scope       = r_rscope;
    assign o_item.result_scope_valid = r_rvalid;
    assign o_item.slot               = r_rslot;
    assign o_item.free_scopes        = 6'(r_sq_cnt);
    assign o_item.free_slots         = 7'(r_vq_cnt);
endmodule

>>> design/scoped_variable_table.sv
// Scope table engine: push/pop scopes, add and look up keyed variable slots.
// One item at a time. Push takes a scope from the free pool; pop walks the
// popped scope's slots and returns each one to the free slot queue; add
// ends the walk at the slot where the key is found, fails when the scope
// misses and no slot is free, and else allocates a new slot and links it
// at the end of the scope; a lookup that misses walks every scope on the
// outer chain, and a hit ends the walk at the matching slot. The walks
// read one slot per cycle from the key, owner and link memories. A failure
// on missing scope or full scope pool returns straight from the decode
// state. Results wait in the output register until taken, and the input is
// ready again in the cycle after the result beat.
module scoped_variable_table #(
    parameter int SCOPE_COUNT = 32,
    parameter int SLOT_COUNT  = 64,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  svt_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output svt_pkg::t_out_item  o_out_data
);
    import svt_pkg::*;

    t_cmd    cmd;
    t_status stat;

    svt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    svt_datapath #(
        .SCOPE_COUNT(SCOPE_COUNT), .SLOT_COUNT(SLOT_COUNT), .KEY_WIDTH(KEY_WIDTH)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_in_data),
        .i_cmd(cmd), .o_stat(stat), .o_item(o_out_data)
    );
endmodule

>>> design/svt_checker.sv
module svt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input svt_pkg::t_out_item o_out_data
);
    // never busy on both sides: one item in flight
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready with result pending");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // counts never exceed pool sizes at default size
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.free_scopes <= 6'd32
                        && o_out_data.free_slots <= 7'd64)
        else $error("free count out of range");

    // a successful beat that names a scope carries slot zero
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.status && o_out_data.result_scope_valid
        |-> o_out_data.slot == 6'd0) else $error("slot set with scope result");
endmodule

bind scoped_variable_table svt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_out_data(o_out_data)
);

>>> tb/sv/scoped_variable_table_tb.sv
`timescale 1ns / 100ps

module scoped_variable_table_tb;
    import svt_pkg::*;

    localparam int NSCOPE = 32;
    localparam int NSLOT = 64;
    localparam int CYCLE_LIMIT = 10000000;

    // Scope table predictor plus queue of expected result beats
    class table_scoreboard;
        logic [4:0] scope_fifo[NSCOPE];
        int scope_head, scope_tail, scope_free;
        int outer_link[NSCOPE];
        int first_slot[NSCOPE];
        int last_slot[NSCOPE];
        logic [5:0] slot_fifo[NSLOT];
        int slot_head, slot_tail, slot_free;
        logic [31:0] key_of[NSLOT];
        int owner_of[NSLOT];
        int next_of[NSLOT];
        t_out_item pending[$];
        int mismatches;

        function void clear();
            for (int i = 0; i < NSCOPE; i++) begin
                scope_fifo[i] = i[4:0];
                outer_link[i] = NSCOPE;
                first_slot[i] = NSLOT;
                last_slot[i] = NSLOT;
            end
            for (int i = 0; i < NSLOT; i++) begin
                slot_fifo[i] = i[5:0];
                key_of[i] = '0;
                owner_of[i] = NSCOPE;
                next_of[i] = NSLOT;
            end
            scope_head = 0; scope_tail = 0; scope_free = NSCOPE;
            slot_head = 0; slot_tail = 0; slot_free = NSLOT;
            pending.delete();
            mismatches = 0;
        endfunction

        function int scope_slot_search(int s, logic [31:0] k);
            int v;
            v = first_slot[s];
            for (int n = 0; n < NSLOT && v < NSLOT; n++) begin
                if (owner_of[v] == s && key_of[v] == k) return v;
                v = next_of[v];
            end
            return NSLOT;
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            int s, v, nx, outer, last;
            r = '0;
            case (t_op'(it.operation))
                OP_PUSH: begin
                    if (scope_free == 0) r.status = 1'b1;
                    else begin
                        s = int'(scope_fifo[scope_head]);
                        scope_head = (scope_head + 1) % NSCOPE;
                        scope_free--;
                        outer_link[s] = it.scope_present ? int'(it.scope) : NSCOPE;
                        first_slot[s] = NSLOT;
                        last_slot[s] = NSLOT;
                        r.result_scope = s[4:0];
                        r.result_scope_valid = 1'b1;
                    end
                end
                OP_POP: begin
                    if (!it.scope_present) r.status = 1'b1;
                    else begin
                        s = int'(it.scope);
                        outer = outer_link[s];
                        v = first_slot[s];
                        for (int n = 0; n < NSLOT && v < NSLOT; n++) begin
                            nx = next_of[v];
                            owner_of[v] = NSCOPE;
                            next_of[v] = NSLOT;
                            if (slot_free < NSLOT) begin
                                slot_fifo[slot_tail] = v[5:0];
                                slot_tail = (slot_tail + 1) % NSLOT;
                                slot_free++;
                            end
                            v = nx;
                        end
                        first_slot[s] = NSLOT;
                        last_slot[s] = NSLOT;
                        outer_link[s] = NSCOPE;
                        if (scope_free < NSCOPE) begin
                            scope_fifo[scope_tail] = s[4:0];
                            scope_tail = (scope_tail + 1) % NSCOPE;
                            scope_free++;
                        end
                        if (outer < NSCOPE) begin
                            r.result_scope = outer[4:0];
                            r.result_scope_valid = 1'b1;
                        end
                    end
                end
                OP_ADD: begin
                    if (!it.scope_present) r.status = 1'b1;
                    else begin
                        s = int'(it.scope);
                        v = scope_slot_search(s, it.var_key);
                        if (v < NSLOT) r.slot = v[5:0];
                        else if (slot_free == 0) r.status = 1'b1;
                        else begin
                            last = last_slot[s];
                            v = int'(slot_fifo[slot_head]);
                            slot_head = (slot_head + 1) % NSLOT;
                            slot_free--;
                            key_of[v] = it.var_key;
                            owner_of[v] = s;
                            next_of[v] = NSLOT;
                            if (last < NSLOT) next_of[last] = v;
                            else first_slot[s] = v;
                            last_slot[s] = v;
                            r.slot = v[5:0];
                        end
                    end
                end
                default: begin
                    s = it.scope_present ? int'(it.scope) : NSCOPE;
                    r.status = 1'b1;
                    for (int n = 0; n < NSCOPE && s < NSCOPE; n++) begin
                        v = scope_slot_search(s, it.var_key);
                        if (v < NSLOT) begin
                            r.status = 1'b0;
                            r.slot = v[5:0];
                            break;
                        end
                        s = outer_link[s];
                    end
                end
            endcase
            r.free_scopes = scope_free[5:0];
            r.free_slots = slot_free[6:0];
            pending.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_item o_out_data;

    table_scoreboard sb;
    int cycle_count = 0;
    bit quiet_phase = 1'b0;
    bit hold_off_req = 1'b0;
    logic [4:0] live_scopes[$];
    logic [31:0] key_pool[8];

    scoped_variable_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("scoped_variable_table verification failed");
            $finish;
        end
    end

    // Result side: check accepted beats, random stalls, one long hold-off
    initial begin
        int stall;
        sb = new();
        sb.clear();
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                hold_off_req = 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (!quiet_phase && stall == 0 && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 13);
                i_out_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_out_ready <= (stall == 0);
            end else i_out_ready <= 1'b1;
        end
    end

    // Send one input beat, with an optional idle burst before it
    task automatic send_beat(t_op op, logic [4:0] sc, logic pres, logic [31:0] k);
        t_in_item it;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        it.operation = op;
        it.scope = sc;
        it.scope_present = pres;
        it.var_key = k;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
        if (op == OP_PUSH && sb.pending[$].result_scope_valid)
            live_scopes.push_back(sb.pending[$].result_scope);
        if (op == OP_POP && pres) begin
            foreach (live_scopes[i])
                if (live_scopes[i] == sc) begin
                    live_scopes.delete(i);
                    break;
                end
        end
    endtask

    function automatic logic [4:0] pick_live();
        if (live_scopes.size() == 0) return 5'($urandom_range(0, 31));
        return live_scopes[$urandom_range(0, live_scopes.size() - 1)];
    endfunction

    task automatic random_beat();
        int r;
        logic [31:0] k;
        r = $urandom_range(0, 99);
        k = ($urandom_range(0, 3) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
        if (r < 4)
            send_beat(OP_POP, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), k);
        else if (r < 7) send_beat(t_op'($urandom_range(0, 3)), pick_live(), 1'b0, k);
        else if (r < 22 || live_scopes.size() == 0)
            send_beat(OP_PUSH, pick_live(), live_scopes.size() != 0 && $urandom_range(0, 3) != 0, k);
        else if (r < 34 && live_scopes.size() > 1)
            send_beat(OP_POP, live_scopes[$], 1'b1, k);
        else if (r < 64) send_beat(OP_ADD, pick_live(), 1'b1, k);
        else send_beat(OP_LOOKUP, pick_live(), 1'b1, k);
    endtask

    // Stimulus
    initial begin
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: missing-scope failures, root push, nested push, adds, lookups, pops
        send_beat(OP_POP, 5'd0, 1'b0, 32'd0);
        send_beat(OP_ADD, 5'd31, 1'b0, 32'd1);
        send_beat(OP_LOOKUP, 5'd0, 1'b0, 32'd1);
        send_beat(OP_PUSH, 5'd31, 1'b0, 32'd0);
        send_beat(OP_PUSH, 5'd0, 1'b1, 32'd0);
        send_beat(OP_ADD, 5'd0, 1'b1, 32'h8000_0000);
        send_beat(OP_ADD, 5'd0, 1'b1, 32'h8000_0000);
        send_beat(OP_ADD, 5'd1, 1'b1, 32'h7fff_ffff);
        send_beat(OP_LOOKUP, 5'd1, 1'b1, 32'h8000_0000);
        send_beat(OP_LOOKUP, 5'd1, 1'b1, 32'hffff_ffff);
        send_beat(OP_LOOKUP, 5'd0, 1'b1, 32'h7fff_ffff);
        send_beat(OP_POP, 5'd1, 1'b1, 32'd0);
        send_beat(OP_POP, 5'd1, 1'b1, 32'd0);
        send_beat(OP_ADD, 5'd1, 1'b1, 32'd5);
        // Exhaust the scope pool, then push once more
        for (int i = 0; i < 32; i++) send_beat(OP_PUSH, 5'd0, 1'b1, 32'd0);
        // Exhaust the slot pool on scope 0
        for (int i = 0; i < 64; i++) send_beat(OP_ADD, 5'd0, 1'b1, i);
        send_beat(OP_LOOKUP, 5'd31, 1'b1, 32'd63);
        send_beat(OP_POP, 5'd0, 1'b1, 32'd0);
        send_beat(OP_POP, 5'd31, 1'b1, 32'd0);

        // Hold off the receiver while the sender keeps offering
        hold_off_req = 1'b1;
        for (int i = 0; i < 30; i++) random_beat();

        // Rebuild tracked live set from scratch: pop what may be live
        live_scopes.delete();
        for (int s = 0; s < 32; s++) send_beat(OP_POP, s[4:0], 1'b1, 32'd0);

        for (int i = 0; i < 1675; i++) begin
            if (i == 1450) quiet_phase = 1'b1;
            random_beat();
        end
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0 && !o_out_valid)
            $display("scoped_variable_table verification clean");
        else
            $display("scoped_variable_table verification failed");
        $finish;
    end
endmodule

>>> sim.f
design/svt_pkg.sv
design/svt_ram.sv
design/svt_ctrl.sv
design/svt_datapath.sv
design/scoped_variable_table.sv
design/svt_checker.sv
tb/sv/scoped_variable_table_tb.sv
